### src/aff2_pkg.sv
// Shared types and defaults for the 2D affine transform unit.
// No dependencies; every other file imports this package.
package aff2_pkg;

   // Default number format: Q16.16 in 32-bit coefficients
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COEF_WIDTH_DEF = 32;

   // Number of stored coefficients (2x3 matrix, row major)
   localparam int MAT_ENTRIES = 6;

   // Item kinds carried on req_tuser
   typedef enum logic [1:0] {
      OP_COMPOSE = 2'd0,
      OP_APPLY   = 2'd1,
      OP_MEASURE = 2'd2
   } op_type;

   // Matrix slots
   localparam int A11 = 0;
   localparam int A12 = 1;
   localparam int A13 = 2;
   localparam int A21 = 3;
   localparam int A22 = 4;
   localparam int A23 = 5;

endpackage

### src/aff2_lin.sv
// One linear term p*u + q*w + (c << FRAC_BITS), arithmetic shift, saturate.
// Depends on aff2_pkg for its parameter defaults; purely combinational.
module aff2_lin #(
   parameter int FRAC_BITS  = aff2_pkg::FRAC_BITS_DEF,
   parameter int COEF_WIDTH = aff2_pkg::COEF_WIDTH_DEF
) (
   input  logic signed [COEF_WIDTH-1:0] p,
   input  logic signed [COEF_WIDTH-1:0] u,
   input  logic signed [COEF_WIDTH-1:0] q,
   input  logic signed [COEF_WIDTH-1:0] w,
   input  logic signed [COEF_WIDTH-1:0] c,
   output logic signed [COEF_WIDTH-1:0] res,
   output logic                         sat
);
   import aff2_pkg::*;

   localparam int PROD_W = 2 * COEF_WIDTH;
   localparam int SUM_W  = 2 * COEF_WIDTH + 2;

   logic signed [PROD_W-1:0]       prod_a;
   logic signed [PROD_W-1:0]       prod_b;
   logic signed [SUM_W-1:0]        c_al;
   logic signed [SUM_W-1:0]        sum;
   logic signed [SUM_W-1:0]        shifted;
   logic [SUM_W-COEF_WIDTH:0]      top_bits;
   logic                           fits;

   assign prod_a  = PROD_W'(p) * PROD_W'(u);
   assign prod_b  = PROD_W'(q) * PROD_W'(w);
   assign c_al    = SUM_W'(c) <<< FRAC_BITS;
   assign sum     = SUM_W'(prod_a) + SUM_W'(prod_b) + c_al;
   assign shifted = sum >>> FRAC_BITS;

   // Result fits when every bit above the kept sign bit repeats it
   assign top_bits = shifted[SUM_W-1:COEF_WIDTH-1];
   assign fits     = (&top_bits) | ~(|top_bits);
   assign sat      = ~fits;

   always_comb begin
      if (fits) begin
         res = shifted[COEF_WIDTH-1:0];
      end else if (shifted[SUM_W-1]) begin
         res = {1'b1, {(COEF_WIDTH-1){1'b0}}};
      end else begin
         res = {1'b0, {(COEF_WIDTH-1){1'b1}}};
      end
   end

endmodule

### src/aff2_datapath.sv
// Six shared linear units: full matrix product on compose, point map on
// apply, scale of x on measure. Depends on aff2_pkg and aff2_lin.
module aff2_datapath #(
   parameter int FRAC_BITS  = aff2_pkg::FRAC_BITS_DEF,
   parameter int COEF_WIDTH = aff2_pkg::COEF_WIDTH_DEF
) (
   input  aff2_pkg::op_type                                     op,
   input  logic [aff2_pkg::MAT_ENTRIES-1:0][COEF_WIDTH-1:0]     mat,
   input  logic [aff2_pkg::MAT_ENTRIES-1:0][COEF_WIDTH-1:0]     sup,
   input  logic [COEF_WIDTH-1:0]                                px,
   input  logic [COEF_WIDTH-1:0]                                py,
   output logic [aff2_pkg::MAT_ENTRIES-1:0][COEF_WIDTH-1:0]     mat_next,
   output logic [COEF_WIDTH-1:0]                                res_x,
   output logic [COEF_WIDTH-1:0]                                res_y,
   output logic                                                 overflow
);
   import aff2_pkg::*;

   logic                      is_compose;
   logic                      is_apply;
   logic                      is_measure;
   logic [COEF_WIDTH-1:0]     u_x;
   logic [COEF_WIDTH-1:0]     w_x;
   logic [COEF_WIDTH-1:0]     c_x;
   logic [COEF_WIDTH-1:0]     c_y;
   logic [MAT_ENTRIES-1:0]    sat;
   logic [COEF_WIDTH-1:0]     zero_w;

   assign zero_w     = '0;
   assign is_compose = (op == OP_COMPOSE);
   assign is_apply   = (op == OP_APPLY);
   assign is_measure = (op == OP_MEASURE);

   // Translation units double as the point units outside compose
   assign u_x = is_compose ? sup[A13] : px;
   assign w_x = is_compose ? sup[A23] : (is_apply ? py : zero_w);
   assign c_x = is_measure ? zero_w : mat[A13];
   assign c_y = mat[A23];

   aff2_lin #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_lin11 (
      .p(mat[A11]), .u(sup[A11]), .q(mat[A12]), .w(sup[A21]), .c(zero_w),
      .res(mat_next[A11]), .sat(sat[A11]));
   aff2_lin #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_lin12 (
      .p(mat[A11]), .u(sup[A12]), .q(mat[A12]), .w(sup[A22]), .c(zero_w),
      .res(mat_next[A12]), .sat(sat[A12]));
   aff2_lin #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_lin13 (
      .p(mat[A11]), .u(u_x), .q(mat[A12]), .w(w_x), .c(c_x),
      .res(mat_next[A13]), .sat(sat[A13]));
   aff2_lin #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_lin21 (
      .p(mat[A21]), .u(sup[A11]), .q(mat[A22]), .w(sup[A21]), .c(zero_w),
      .res(mat_next[A21]), .sat(sat[A21]));
   aff2_lin #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_lin22 (
      .p(mat[A21]), .u(sup[A12]), .q(mat[A22]), .w(sup[A22]), .c(zero_w),
      .res(mat_next[A22]), .sat(sat[A22]));
   aff2_lin #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_lin23 (
      .p(mat[A21]), .u(u_x), .q(mat[A22]), .w(w_x), .c(c_y),
      .res(mat_next[A23]), .sat(sat[A23]));

   assign res_x    = mat_next[A13];
   assign res_y    = is_measure ? zero_w : mat_next[A23];
   assign overflow = sat[A13] | (is_apply & sat[A23]);

endmodule

### src/affine_transform_2d_unit_top.sv
// A request beat is registered in the input stage, and its result in the result register.
// Throughput: one item per cycle; a waiting result stalls req_tready only once an
// apply or measure also sits in the input stage, and rsp_tready reaches req_tready
// combinationally. A compose updates the matrix as it leaves the input stage, so
// the very next item already sees the new matrix.
// Reset clears both valids and loads the identity matrix.
module affine_transform_2d_unit_top #(
   parameter int FRAC_BITS  = aff2_pkg::FRAC_BITS_DEF,
   parameter int COEF_WIDTH = aff2_pkg::COEF_WIDTH_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_tvalid,
   output logic                                             req_tready,
   // m11, m12, m13, m21, m22, m23, px, py (lowest first), zero padded
   input  logic [((8*COEF_WIDTH+7)/8)*8-1:0]                req_tdata,
   // op
   input  logic [1:0]                                       req_tuser,
   output logic                                             rsp_tvalid,
   input  logic                                             rsp_tready,
   // res_x, res_y (lowest first), zero padded
   output logic [((2*COEF_WIDTH+7)/8)*8-1:0]                rsp_tdata,
   // overflow
   output logic [0:0]                                       rsp_tuser
);
   import aff2_pkg::*;

   localparam int RSP_DATA_W = ((2*COEF_WIDTH+7)/8)*8;
   localparam logic [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam logic [COEF_WIDTH-1:0] ONE_Q =
      (FRAC_BITS < COEF_WIDTH-1) ? (COEF_WIDTH'(1) << FRAC_BITS) : COEF_MAX;

   // Input stage
   logic                                       stg_vld_ff, stg_vld_in;
   op_type                                     stg_op_ff;
   logic [MAT_ENTRIES-1:0][COEF_WIDTH-1:0]     stg_sup_ff;
   logic [COEF_WIDTH-1:0]                      stg_px_ff;
   logic [COEF_WIDTH-1:0]                      stg_py_ff;

   // Stored matrix
   logic [MAT_ENTRIES-1:0][COEF_WIDTH-1:0]     mat_ff, mat_in;
   logic [MAT_ENTRIES-1:0][COEF_WIDTH-1:0]     mat_next;
   logic [MAT_ENTRIES-1:0][COEF_WIDTH-1:0]     mat_rst;

   // Result register
   logic                                       rsp_vld_ff, rsp_vld_in;
   logic [COEF_WIDTH-1:0]                      rsp_x_ff;
   logic [COEF_WIDTH-1:0]                      rsp_y_ff;
   logic                                       rsp_ovf_ff;

   logic [COEF_WIDTH-1:0]                      res_x;
   logic [COEF_WIDTH-1:0]                      res_y;
   logic                                       res_ovf;

   logic req_take;
   logic stg_gives;
   logic out_free;
   logic stg_adv;
   logic rsp_load;

   assign stg_gives  = (stg_op_ff == OP_APPLY) | (stg_op_ff == OP_MEASURE);
   assign out_free   = ~rsp_vld_ff | rsp_tready;
   assign stg_adv    = stg_vld_ff & (~stg_gives | out_free);
   assign rsp_load   = stg_adv & stg_gives;
   assign req_tready = ~stg_vld_ff | stg_adv;
   assign req_take   = req_tvalid & req_tready;

   assign stg_vld_in = req_take | (stg_vld_ff & ~stg_adv);
   assign rsp_vld_in = rsp_load | (rsp_vld_ff & ~rsp_tready);
   assign mat_in     = (stg_adv & (stg_op_ff == OP_COMPOSE)) ? mat_next : mat_ff;

   // Identity: unit diagonal, everything else zero
   always_comb begin
      mat_rst      = '0;
      mat_rst[A11] = ONE_Q;
      mat_rst[A22] = ONE_Q;
   end

   aff2_datapath #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_datapath (
      .op       (stg_op_ff),
      .mat      (mat_ff),
      .sup      (stg_sup_ff),
      .px       (stg_px_ff),
      .py       (stg_py_ff),
      .mat_next (mat_next),
      .res_x    (res_x),
      .res_y    (res_y),
      .overflow (res_ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         mat_ff     <= mat_rst;
      end else begin
         stg_vld_ff <= stg_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         mat_ff     <= mat_in;
      end
   end

   // Payload registers: hold unless a new beat is loaded
   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_op_ff  <= op_type'(req_tuser);
         stg_sup_ff <= req_tdata[MAT_ENTRIES*COEF_WIDTH-1:0];
         stg_px_ff  <= req_tdata[7*COEF_WIDTH-1:6*COEF_WIDTH];
         stg_py_ff  <= req_tdata[8*COEF_WIDTH-1:7*COEF_WIDTH];
      end
      if (rsp_load) begin
         rsp_x_ff   <= res_x;
         rsp_y_ff   <= res_y;
         rsp_ovf_ff <= res_ovf;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_ovf_ff;

`ifndef SYNTHESIS
   // A compose or an unused code never loads the result register
   assert property (@(posedge clock) disable iff (reset)
      (stg_vld_ff & ~stg_gives) |-> !rsp_load)
      else $error("result loaded by an item that gives none");

   // The matrix moves only when a compose leaves the input stage
   assert property (@(posedge clock) disable iff (reset)
      !(stg_adv & (stg_op_ff == OP_COMPOSE)) |=> $stable(mat_ff))
      else $error("matrix changed without a compose");

   // A flagged result carries a clamped value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff & rsp_ovf_ff) |->
         (rsp_x_ff == COEF_MAX) || (rsp_x_ff == COEF_MIN) ||
         (rsp_y_ff == COEF_MAX) || (rsp_y_ff == COEF_MIN))
      else $error("overflow flag without a saturated value");
`endif

endmodule
